// ===== src/lpls_pkg.sv =====
// shared constants, command and status types for the load paced led scanner
`timescale 1ns / 1ps

package lpls_pkg;

    // field widths
    localparam int LOAD_W    = 24;
    localparam int MAP_W     = 32;
    localparam int LED_W     = 16;
    localparam int IVL_W     = 7;

    // scan geometry
    localparam int POSITIONS = 8;
    localparam int IDX_W     = $clog2(POSITIONS);
    localparam int ENTRY_W   = 4;

    // reload arithmetic: 110 - (300 << FRAC_BITS) / (load / 5 + (3 << FRAC_BITS))
    localparam int FRAC_BITS    = 11;
    localparam int INTERVAL_MAX = 110;
    localparam int NUM_VAL      = 300 << FRAC_BITS;
    localparam int BIAS_VAL     = 3 << FRAC_BITS;
    localparam int REM_W        = $clog2(NUM_VAL + 1);
    localparam int Q_W          = 7;
    localparam int CNT_W        = $clog2(Q_W);

    // load / 5 as multiply by reciprocal, exact for any 24-bit load
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = 2 * LOAD_W;
    localparam int DEN_W       = PROD_W - RECIP_SHIFT;
    localparam int DSOR_W      = DEN_W + Q_W - 1;

    localparam logic [LOAD_W-1:0] RECIP_MUL = LOAD_W'(((1 << RECIP_SHIFT) + 4) / 5);
    localparam logic [MAP_W-1:0]  MAP_RESET = 32'h7654_3210;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic div_init;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/lpls_ctrl.sv =====
// controller state machine sequencing capture, divide and commit of one tick
`timescale 1ns / 1ps

module lpls_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpls_pkg::t_dp_sts  i_sts,
    output lpls_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [lpls_pkg::CNT_W-1:0]  r_cnt;
    logic [lpls_pkg::CNT_W-1:0]  n_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = lpls_pkg::CNT_W'(lpls_pkg::Q_W - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // an accepted word always runs the full divide before commit
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_PREP))
        else $error("accepted word did not start the reload computation");

    a_commit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && $past(r_state) == S_DIV) |-> ($past(r_cnt) == '0))
        else $error("divide left early");

    a_single_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.div_init, o_cmd.div_step, o_cmd.commit}))
        else $error("more than one datapath command at once");

endmodule

// ===== src/lpls_dp.sv =====
// datapath: load scaling, restoring divider, scan state, led map and output word
`timescale 1ns / 1ps

module lpls_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpls_pkg::t_dp_cmd             i_cmd,
    output lpls_pkg::t_dp_sts             o_sts,
    input  logic [lpls_pkg::LOAD_W-1:0]   i_load_average,
    input  logic                          i_cfg_valid,
    input  logic [lpls_pkg::MAP_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lpls_pkg::LED_W-1:0]    o_led_pattern,
    output logic                          o_strobe_res,
    output logic [lpls_pkg::IVL_W-1:0]    o_next_interval
);

    logic [lpls_pkg::MAP_W-1:0]   r_led_map;
    logic [lpls_pkg::PROD_W-1:0]  r_prod;
    logic [lpls_pkg::DSOR_W-1:0]  r_dsor;
    logic [lpls_pkg::REM_W-1:0]   r_rem;
    logic [lpls_pkg::Q_W-1:0]     r_quo;
    logic [lpls_pkg::IDX_W-1:0]   r_scan_index;
    logic                         r_scan_down;
    logic [lpls_pkg::IVL_W-1:0]   r_ticks_left;
    logic [lpls_pkg::LED_W-1:0]   r_led_word;
    logic                         r_strobe;
    logic                         r_out_valid;

    logic [lpls_pkg::DEN_W-1:0]   den;
    logic                         ge;
    logic [lpls_pkg::IVL_W-1:0]   ticks_dec;
    logic                         expire;
    logic [lpls_pkg::ENTRY_W-1:0] pos;
    logic [lpls_pkg::IDX_W-1:0]   n_scan_index;
    logic                         n_scan_down;
    logic [lpls_pkg::IVL_W-1:0]   reload;

    // divisor: load / 5 + bias, from the registered reciprocal product
    assign den = r_prod[lpls_pkg::PROD_W-1 -: lpls_pkg::DEN_W]
               + lpls_pkg::DEN_W'(lpls_pkg::BIAS_VAL);
    assign ge  = (lpls_pkg::DSOR_W'(r_rem) >= r_dsor);

    // scale and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod <= lpls_pkg::PROD_W'(i_load_average)
                    * lpls_pkg::PROD_W'(lpls_pkg::RECIP_MUL);
        end
        if (i_cmd.div_init) begin
            r_dsor <= {den, {(lpls_pkg::Q_W - 1){1'b0}}};
            r_rem  <= lpls_pkg::REM_W'(lpls_pkg::NUM_VAL);
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsor[lpls_pkg::REM_W-1:0];
            end
            r_quo  <= {r_quo[lpls_pkg::Q_W-2:0], ge};
            r_dsor <= r_dsor >> 1;
        end
    end

    // countdown and scan step
    assign ticks_dec = (r_ticks_left == '0) ? '0 : r_ticks_left - 1'b1;
    assign expire    = (ticks_dec == '0);
    assign pos       = r_led_map[r_scan_index * lpls_pkg::ENTRY_W +: lpls_pkg::ENTRY_W];
    assign reload    = lpls_pkg::IVL_W'(lpls_pkg::INTERVAL_MAX) - r_quo;

    always_comb begin
        if (r_scan_down) begin
            n_scan_index = (r_scan_index == '0) ? '0 : r_scan_index - 1'b1;
        end else if (r_scan_index == lpls_pkg::IDX_W'(lpls_pkg::POSITIONS - 1)) begin
            n_scan_index = '0;
        end else begin
            n_scan_index = r_scan_index + 1'b1;
        end
        n_scan_down = r_scan_down;
        if (n_scan_index == '0
            || n_scan_index == lpls_pkg::IDX_W'(lpls_pkg::POSITIONS - 1)) begin
            n_scan_down = !r_scan_down;
        end
    end

    // config register, scan state and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_map    <= lpls_pkg::MAP_RESET;
            r_scan_index <= '0;
            r_scan_down  <= 1'b0;
            r_ticks_left <= lpls_pkg::IVL_W'(1);
            r_led_word   <= '0;
            r_strobe     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_led_map <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_strobe    <= expire;
                if (expire) begin
                    r_led_word   <= lpls_pkg::LED_W'(1) << pos;
                    r_scan_index <= n_scan_index;
                    r_scan_down  <= n_scan_down;
                    r_ticks_left <= reload;
                end else begin
                    r_ticks_left <= ticks_dec;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_led_pattern   = r_led_word;
    assign o_strobe_res    = r_strobe;
    assign o_next_interval = r_ticks_left;

    a_strobe_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_strobe) |-> $onehot(r_led_word))
        else $error("strobe word is not one-hot");

    a_reload_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_strobe) |-> (r_ticks_left >= lpls_pkg::IVL_W'(10)
            && r_ticks_left <= lpls_pkg::IVL_W'(lpls_pkg::INTERVAL_MAX)))
        else $error("reload interval out of range");

    a_word_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("output word appeared without commit");

endmodule

// ===== src/load_paced_led_scanner.sv =====
// top level of the load paced led scanner
//
// usage: each input word is one system tick carrying the load average
// (24-bit unsigned, 11 fraction bits). every tick gives exactly one output
// word: the led pattern, a strobe flag and the ticks left to the next strobe.
// input channel i_in_valid / o_in_stall, output channel o_out_valid /
// i_out_stall; a word moves when valid is high and stall is low.
// the output word follows the accepting edge through capture with
// reciprocal multiply, divisor setup, 7 restoring divide steps and commit.
// one tick is in flight at a time, so a new word is taken only after the
// previous tick has committed its output word.
// the led map register is written over i_cfg_valid / o_cfg_ready, ready
// always high; write it only while no tick is in flight.
// synchronous reset (i_rst_n low) restores the identity map, scan index 0
// moving upward, countdown 1 and a dark led word; the first tick strobes.
// when the receiver stalls the output word holds and the finished tick
// waits in the controller; input stays stalled until the held word is
// taken and the finished tick moves into the output register.
`timescale 1ns / 1ps

module load_paced_led_scanner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lpls_pkg::LOAD_W-1:0]   i_load_average,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lpls_pkg::LED_W-1:0]    o_led_pattern,
    output logic                          o_strobe_res,
    output logic [lpls_pkg::IVL_W-1:0]    o_next_interval,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpls_pkg::MAP_W-1:0]    i_cfg_data
);

    lpls_pkg::t_dp_cmd cmd;
    lpls_pkg::t_dp_sts sts;

    // config writes are taken at any time
    assign o_cfg_ready = 1'b1;

    // sequencing
    lpls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic and scan state
    lpls_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_load_average  (i_load_average),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_led_pattern   (o_led_pattern),
        .o_strobe_res    (o_strobe_res),
        .o_next_interval (o_next_interval)
    );

endmodule
